// ===== sv/minv_pkg.sv =====
// minv_pkg: shared types and constants for the modular inverse block
// used by the interfaces, the sequencer, the datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package minv_pkg;

    localparam int MINV_MOD_BITS   = 31;
    localparam int MINV_VALUE_BITS = 32;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ALIGN,
        S_SUB,
        S_SWAP,
        S_FIX,
        S_WRAP,
        S_FINISH
    } t_state;

    // datapath operations issued by the sequencer
    typedef enum logic [2:0] {
        DP_HOLD,
        DP_LOAD,
        DP_ALIGN,
        DP_SUB,
        DP_SWAP,
        DP_FIX,
        DP_WRAP
    } t_dp_op;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic borrow;
        logic k_zero;
        logic rem_gt1;
        logic rem_zero;
        logic mod_small;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== sv/minv_if.sv =====
// minv_in_if / minv_out_if: valid/ready channels of the modular inverse block
// depends on minv_pkg
`timescale 1ns / 1ps
`default_nettype none

interface minv_in_if #(
    parameter int MOD_BITS = minv_pkg::MINV_MOD_BITS
);
    import minv_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [MINV_VALUE_BITS-1:0] value;
    logic [MOD_BITS-1:0]        modulus;

    modport source (output valid, output value, output modulus, input ready);
    modport sink   (input valid, input value, input modulus, output ready);
endinterface

interface minv_out_if #(
    parameter int MOD_BITS = minv_pkg::MINV_MOD_BITS
);
    logic                valid;
    logic                ready;
    logic [MOD_BITS-1:0] inverse_value;
    logic                no_inverse;

    modport source (output valid, output inverse_value, output no_inverse, input ready);
    modport sink   (input valid, input inverse_value, input no_inverse, output ready);
endinterface

`default_nettype wire

// ===== sv/modular_inverse_32.sv =====
// modular_inverse_32: modular inverse by the extended euclidean algorithm
// steps: each euclid step aligns the divisor, subtracts one quotient bit at a time and swaps, then
// sign fix, wrap and finish follow; a modulus below 2 goes straight to finish, and a value that
// reduces to zero ends with no inverse; align and subtract use the one shared subtractor
// throughput: one item at a time, input ready only while idle, after each result is loaded
// reset: synchronous active-low i_rst_n clears the sequencer and the output valid
`timescale 1ns / 1ps
`default_nettype none

module modular_inverse_32 #(
    parameter int MOD_BITS = minv_pkg::MINV_MOD_BITS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    minv_in_if.sink   i_in,
    minv_out_if.source o_out
);
    import minv_pkg::*;

    t_dp_op              w_op;
    t_dp_stat            w_stat;
    logic                w_in_ready;
    logic                w_res_load;
    logic                w_no_inv;
    logic                w_out_free;
    logic [MOD_BITS-1:0] w_result;

    // output holding register
    logic                r_out_valid;
    logic [MOD_BITS-1:0] r_inverse_value;
    logic                r_no_inverse;

    // output stage can take a new result when empty or being drained
    assign w_out_free = !r_out_valid || o_out.ready;

    // sequencer: load, align divisor, shift-subtract quotient bits, swap, fix sign, wrap and finish
    minv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_op       (w_op),
        .o_in_ready (w_in_ready),
        .o_res_load (w_res_load),
        .o_no_inv   (w_no_inv)
    );

    // remainders, coefficients and the shared subtractor
    minv_dpath #(
        .MOD_BITS (MOD_BITS)
    ) u_dpath (
        .i_clk     (i_clk),
        .i_op      (w_op),
        .i_value   (i_in.value),
        .i_modulus (i_in.modulus),
        .o_stat    (w_stat),
        .o_result  (w_result)
    );

    assign i_in.ready = w_in_ready;

    // valid flag for the result transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, forced to zero when there is no inverse
    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_inverse_value <= w_no_inv ? '0 : w_result;
            r_no_inverse    <= w_no_inv;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.inverse_value = r_inverse_value;
    assign o_out.no_inverse    = r_no_inverse;

endmodule

`default_nettype wire

// ===== sv/minv_dpath.sv =====
// minv_dpath: euclid registers around one shared subtractor and one adder
// depends on minv_pkg
`timescale 1ns / 1ps
`default_nettype none

module minv_dpath #(
    parameter int MOD_BITS = minv_pkg::MINV_MOD_BITS
) (
    input  wire logic                                 i_clk,
    input  var minv_pkg::t_dp_op                      i_op,
    input  wire logic [minv_pkg::MINV_VALUE_BITS-1:0] i_value,
    input  wire logic [MOD_BITS-1:0]                  i_modulus,
    output minv_pkg::t_dp_stat                        o_stat,
    output logic [MOD_BITS-1:0]                       o_result
);
    import minv_pkg::*;

    localparam int UW = MOD_BITS + 1;
    localparam int RW = (UW > MINV_VALUE_BITS) ? UW : MINV_VALUE_BITS;
    localparam int SW = RW + 1;
    localparam int KW = $clog2(RW + 1);

    logic [RW-1:0]       r_ra;
    logic [RW-1:0]       r_rb;
    logic [RW-1:0]       r_d;
    logic [MOD_BITS-1:0] r_e;
    logic [UW-1:0]       r_ua;
    logic [UW-1:0]       r_ub;
    logic [KW-1:0]       r_k;
    logic [MOD_BITS-1:0] r_m;
    logic                r_neg;

    logic [SW-1:0] w_sub_a;
    logic [SW-1:0] w_sub_b;
    logic [SW:0]   w_diff;
    logic          w_borrow;

    // shared subtractor, operands picked per operation
    always_comb begin
        w_sub_a = '0;
        w_sub_b = '0;
        unique case (i_op)
            DP_ALIGN: begin
                w_sub_a = SW'(r_ra);
                w_sub_b = {r_d, 1'b0};
            end
            DP_SUB: begin
                w_sub_a = SW'(r_ra);
                w_sub_b = SW'(r_d);
            end
            DP_FIX: begin
                w_sub_a = SW'(r_m);
                w_sub_b = SW'(r_ub);
            end
            DP_WRAP: begin
                w_sub_a = SW'(r_ua);
                w_sub_b = SW'(r_m);
            end
            default: begin
            end
        endcase
    end

    assign w_diff   = {1'b0, w_sub_a} - {1'b0, w_sub_b};
    assign w_borrow = w_diff[SW];

    assign o_stat.borrow    = w_borrow;
    assign o_stat.k_zero    = (r_k == '0);
    assign o_stat.rem_gt1   = (r_ra[RW-1:1] != '0);
    assign o_stat.rem_zero  = (r_ra == '0);
    assign o_stat.mod_small = (i_modulus[MOD_BITS-1:1] == '0);
    assign o_result         = r_ua[MOD_BITS-1:0];

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            DP_LOAD: begin
                // first pass divides value by modulus, coefficients set so the
                // swap leaves (m, value mod m) with coefficients 0 and 1
                r_ra  <= RW'(i_value);
                r_rb  <= RW'(i_modulus);
                r_d   <= RW'(i_modulus);
                r_e   <= '0;
                r_ua  <= UW'(1);
                r_ub  <= '0;
                r_k   <= '0;
                r_neg <= 1'b1;
                r_m   <= i_modulus;
            end
            DP_ALIGN: begin
                if (!w_borrow) begin
                    r_d <= {r_d[RW-2:0], 1'b0};
                    r_e <= {r_e[MOD_BITS-2:0], 1'b0};
                    r_k <= r_k + KW'(1);
                end
            end
            DP_SUB: begin
                if (!w_borrow) begin
                    r_ra <= w_diff[RW-1:0];
                    r_ua <= r_ua + UW'(r_e);
                end
                r_d <= r_d >> 1;
                r_e <= r_e >> 1;
                if (r_k != '0) begin
                    r_k <= r_k - KW'(1);
                end
            end
            DP_SWAP: begin
                r_ra  <= r_rb;
                r_rb  <= r_ra;
                r_ua  <= r_ub;
                r_ub  <= r_ua;
                r_d   <= r_ra;
                r_e   <= r_ua[MOD_BITS-1:0];
                r_k   <= '0;
                r_neg <= ~r_neg;
            end
            DP_FIX: begin
                r_ua <= r_neg ? w_diff[UW-1:0] : r_ub;
            end
            DP_WRAP: begin
                if (!w_borrow) begin
                    r_ua <= w_diff[UW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/minv_ctrl.sv =====
// minv_ctrl: sequencer stepping the datapath through euclid divisions
// depends on minv_pkg
`timescale 1ns / 1ps
`default_nettype none

module minv_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    input  wire logic         i_out_free,
    input  var minv_pkg::t_dp_stat i_stat,
    output minv_pkg::t_dp_op  o_op,
    output logic              o_in_ready,
    output logic              o_res_load,
    output logic              o_no_inv
);
    import minv_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_no_inv;
    logic   n_no_inv;

    // next state
    always_comb begin
        n_state  = r_state;
        n_no_inv = r_no_inv;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_no_inv = i_stat.mod_small;
                    n_state  = i_stat.mod_small ? S_FINISH : S_ALIGN;
                end
            end
            S_ALIGN: begin
                if (i_stat.borrow) begin
                    n_state = S_SUB;
                end
            end
            S_SUB: begin
                if (i_stat.k_zero) begin
                    n_state = S_SWAP;
                end
            end
            S_SWAP: begin
                priority if (i_stat.rem_gt1) begin
                    n_state = S_ALIGN;
                end else if (i_stat.rem_zero) begin
                    n_no_inv = 1'b1;
                    n_state  = S_FINISH;
                end else begin
                    n_state = S_FIX;
                end
            end
            S_FIX:    n_state = S_WRAP;
            S_WRAP:   n_state = S_FINISH;
            S_FINISH: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_op       = DP_HOLD;
        o_in_ready = 1'b0;
        o_res_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op = DP_LOAD;
                end
            end
            S_ALIGN:  o_op = DP_ALIGN;
            S_SUB:    o_op = DP_SUB;
            S_SWAP:   o_op = DP_SWAP;
            S_FIX:    o_op = DP_FIX;
            S_WRAP:   o_op = DP_WRAP;
            S_FINISH: o_res_load = i_out_free;
            default:  o_op = DP_HOLD;
        endcase
    end

    assign o_no_inv = r_no_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_no_inv <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_no_inv <= n_no_inv;
        end
    end

endmodule

`default_nettype wire

// ===== sv/minv_checker.sv =====
// minv_checker: port-level assertions for modular_inverse_32, attached by bind
// depends on minv_pkg and the top level
`timescale 1ns / 1ps
`default_nettype none

module minv_checker #(
    parameter int MOD_BITS = minv_pkg::MINV_MOD_BITS
) (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                i_in_ready,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire logic [MOD_BITS-1:0] i_inverse_value,
    input wire logic                i_no_inverse
);

    // result held steady while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_inverse_value) && $stable(i_no_inverse))
        else $error("result changed while stalled");

    // a real inverse is never zero, and no inverse always reads zero
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_no_inverse == (i_inverse_value == '0)))
        else $error("no_inverse does not match inverse value");

    // one item at a time: no new transfer the cycle after one is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after a transfer");

    // a result cannot appear the cycle after the input transfer
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid |=> !i_out_valid)
        else $error("result too early");

endmodule

bind modular_inverse_32 minv_checker #(
    .MOD_BITS (MOD_BITS)
) u_minv_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_inverse_value (o_out.inverse_value),
    .i_no_inverse    (o_out.no_inverse)
);

`default_nettype wire
